FILE: hw/rtl/lrab_pkg.sv
package lrab_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_READY      = 3'd0,
        ST_FETCH      = 3'd1,
        ST_ERROR      = 3'd2,
        ST_BUSY       = 3'd3,
        ST_UNEXPECTED = 3'd4
    } t_status;

    // input item kinds
    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_OUTCOME = 1'b1
    } t_kind;

    localparam int unsigned LBA_W    = 32;
    localparam int unsigned WIN_W    = 3;
    localparam int unsigned OFF_W    = 8;
    localparam int unsigned FCNT_W   = 9;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 2;

    // register byte addresses
    localparam logic [APB_AW-1:0] ADDR_DISK_END = 2'd0;

endpackage

FILE: hw/rtl/lrab_if.sv
interface lrab_req_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [lrab_pkg::LBA_W-1:0] lba;
    logic                       fetch_ok;

    modport source (output valid, output kind, output lba, output fetch_ok, input ready);
    modport sink   (input valid, input kind, input lba, input fetch_ok, output ready);
endinterface

interface lrab_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [lrab_pkg::WIN_W-1:0]  window;
    logic [lrab_pkg::OFF_W-1:0]  sector_offset;
    logic [lrab_pkg::LBA_W-1:0]  fetch_lba;
    logic [lrab_pkg::FCNT_W-1:0] fetch_count;

    modport source (output valid, output status, output window, output sector_offset,
                    output fetch_lba, output fetch_count, input ready);
    modport sink   (input valid, input status, input window, input sector_offset,
                    input fetch_lba, input fetch_count, output ready);
endinterface

FILE: hw/rtl/lru_read_ahead_window_buffer_core.sv
// a request or fetch outcome appears at the result register in the cycle after it is taken
// throughput: one transaction per cycle; tag compare and victim pick settle in a single pass
// a new transaction is taken whenever the result register is empty or is drained that cycle
// reset (synchronous, active low) empties all windows, clears ages, use clock and pending fetch
// the disk end register resets to zero, so the end-of-disk clamp starts disabled
module lru_read_ahead_window_buffer_core #(
    parameter int unsigned WINDOW_SECTORS = 64,
    parameter int unsigned NUM_WINDOWS    = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lrab_req_if.sink                       i_req,
    lrab_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lrab_pkg::APB_AW-1:0]    paddr,
    input  logic [lrab_pkg::APB_DW-1:0]    pwdata,
    output logic [lrab_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import lrab_pkg::*;

    localparam int unsigned FILL_W = $clog2(WINDOW_SECTORS + 1);
    localparam int unsigned IDX_W  = $clog2(NUM_WINDOWS);

    // window state
    logic [LBA_W-1:0]  r_win_start [NUM_WINDOWS];
    logic [FILL_W-1:0] r_win_fill  [NUM_WINDOWS];
    logic [LBA_W-1:0]  r_win_age   [NUM_WINDOWS];
    logic [LBA_W-1:0]  n_win_start [NUM_WINDOWS];
    logic [FILL_W-1:0] n_win_fill  [NUM_WINDOWS];
    logic [LBA_W-1:0]  n_win_age   [NUM_WINDOWS];
    logic [LBA_W-1:0]  r_use_clock, n_use_clock;
    logic              r_pending, n_pending;
    logic [LBA_W-1:0]  r_pend_start, n_pend_start;
    logic [FILL_W-1:0] r_pend_count, n_pend_count;
    logic [IDX_W-1:0]  r_pend_win, n_pend_win;
    logic [LBA_W-1:0]  r_disk_end;

    // result register
    logic              r_o_valid;
    t_status           r_o_status, n_o_status;
    logic [WIN_W-1:0]  r_o_window, n_o_window;
    logic [OFF_W-1:0]  r_o_off, n_o_off;
    logic [LBA_W-1:0]  r_o_flba, n_o_flba;
    logic [FCNT_W-1:0] r_o_fcnt, n_o_fcnt;

    logic              acc;
    logic              cfg_wr;
    logic [LBA_W-1:0]  diff [NUM_WINDOWS];
    logic              hit  [NUM_WINDOWS];
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  victim;
    logic [LBA_W-1:0]  last_diff;
    logic              clamp;
    logic [FILL_W-1:0] count;

    assign i_req.ready = !r_o_valid || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_DISK_END);
    assign prdata = (paddr == ADDR_DISK_END) ? r_disk_end : '0;

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.window        = r_o_window;
    assign o_rsp.sector_offset = r_o_off;
    assign o_rsp.fetch_lba     = r_o_flba;
    assign o_rsp.fetch_count   = r_o_fcnt;

    always_comb begin
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            diff[i] = i_req.lba - r_win_start[i];
            hit[i]  = (r_win_fill[i] != '0) && (i_req.lba >= r_win_start[i])
                      && (diff[i] < LBA_W'(r_win_fill[i]));
        end
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            if (!hit_found && hit[i]) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
        end
        // first window holding the strictly smallest age
        victim = '0;
        for (int i = 1; i < NUM_WINDOWS; i++) begin
            if (r_win_age[i] < r_win_age[victim]) begin
                victim = IDX_W'(i);
            end
        end
        last_diff = r_disk_end - i_req.lba;
        clamp     = (r_disk_end != '0) && (i_req.lba <= r_disk_end)
                    && (last_diff < LBA_W'(WINDOW_SECTORS - 1));
        count     = clamp ? FILL_W'(last_diff + LBA_W'(1)) : FILL_W'(WINDOW_SECTORS);
    end

    always_comb begin
        n_win_start  = r_win_start;
        n_win_fill   = r_win_fill;
        n_win_age    = r_win_age;
        n_use_clock  = r_use_clock;
        n_pending    = r_pending;
        n_pend_start = r_pend_start;
        n_pend_count = r_pend_count;
        n_pend_win   = r_pend_win;
        n_o_status   = ST_READY;
        n_o_window   = '0;
        n_o_off      = '0;
        n_o_flba     = '0;
        n_o_fcnt     = '0;
        if (i_req.kind == KIND_OUTCOME) begin
            if (!r_pending) begin
                n_o_status = ST_UNEXPECTED;
            end else if (i_req.fetch_ok) begin
                n_win_start[r_pend_win] = r_pend_start;
                n_win_fill[r_pend_win]  = r_pend_count;
                n_use_clock             = r_use_clock + LBA_W'(1);
                n_win_age[r_pend_win]   = n_use_clock;
                n_pending               = 1'b0;
                n_o_status              = ST_READY;
                n_o_window              = WIN_W'(r_pend_win);
            end else if (r_pend_count > FILL_W'(1)) begin
                // retry the failed multi-sector fetch as a single-sector fetch of its first sector
                n_pend_count = FILL_W'(1);
                n_o_status   = ST_FETCH;
                n_o_window   = WIN_W'(r_pend_win);
                n_o_flba     = r_pend_start;
                n_o_fcnt     = FCNT_W'(1);
            end else begin
                n_pending  = 1'b0;
                n_o_status = ST_ERROR;
                n_o_window = WIN_W'(r_pend_win);
            end
        end else if (r_pending) begin
            n_o_status = ST_BUSY;
        end else if (hit_found) begin
            n_use_clock         = r_use_clock + LBA_W'(1);
            n_win_age[hit_idx]  = n_use_clock;
            n_o_status          = ST_READY;
            n_o_window          = WIN_W'(hit_idx);
            n_o_off             = OFF_W'(diff[hit_idx]);
        end else begin
            n_win_fill[victim] = '0;
            n_pending          = 1'b1;
            n_pend_start       = i_req.lba;
            n_pend_count       = count;
            n_pend_win         = victim;
            n_o_status         = ST_FETCH;
            n_o_window         = WIN_W'(victim);
            n_o_flba           = i_req.lba;
            n_o_fcnt           = FCNT_W'(count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                r_win_start[i] <= '0;
                r_win_fill[i]  <= '0;
                r_win_age[i]   <= '0;
            end
            r_use_clock  <= '0;
            r_pending    <= 1'b0;
            r_pend_start <= '0;
            r_pend_count <= '0;
            r_pend_win   <= '0;
            r_disk_end   <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_disk_end <= pwdata;
            end
            if (acc) begin
                r_win_start  <= n_win_start;
                r_win_fill   <= n_win_fill;
                r_win_age    <= n_win_age;
                r_use_clock  <= n_use_clock;
                r_pending    <= n_pending;
                r_pend_start <= n_pend_start;
                r_pend_count <= n_pend_count;
                r_pend_win   <= n_pend_win;
                r_o_valid    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_o_status <= n_o_status;
            r_o_window <= n_o_window;
            r_o_off    <= n_o_off;
            r_o_flba   <= n_o_flba;
            r_o_fcnt   <= n_o_fcnt;
        end
    end

    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_o_valid)
        else $error("accepted transaction produced no result");

    a_pending_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending && !(acc && i_req.kind == KIND_OUTCOME)) |=> r_pending)
        else $error("pending fetch dropped without an outcome");

    a_clock_only_on_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_use_clock != $past(r_use_clock)) |-> ($past(acc) && r_o_status == ST_READY))
        else $error("use clock advanced without a ready result");

    a_fetch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_FETCH) |-> (r_o_fcnt != '0))
        else $error("fetch issued with zero sectors");

endmodule
